// ===== rtl/swa_pkg.sv =====
// Shared types and constants of the sliding time-window average block.
package swa_pkg;

  // Field widths that are fixed by the interface.
  localparam int unsigned CH_W     = 3;
  localparam int unsigned TS_W     = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned AVG_W    = 48;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WLEN_W   = 7;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;

  // Function codes of an input word.
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Status codes of a result word.
  localparam logic [1:0] STAT_ADDED = 2'd0;
  localparam logic [1:0] STAT_STALE = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;
  localparam logic [1:0] STAT_AVG   = 2'd3;

  // Class that the front end gives each word.
  typedef enum logic [1:0] {
    CLS_ADD,
    CLS_GET,
    CLS_BAD_ADD,
    CLS_BAD_GET
  } cls_e;

  typedef struct packed {
    logic               func;
    logic [CH_W-1:0]    channel;
    logic [TS_W-1:0]    timestamp;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [AVG_W-1:0] average;
    logic                    empty_res;
  } out_t;

  // One entry of the queue between front and back.
  typedef struct packed {
    cls_e                    cls;
    logic [CH_W-1:0]         channel;
    logic [TS_W-1:0]         timestamp;
    logic signed [VAL_W-1:0] value;
  } qent_t;

  // One time bucket as stored in the slot memory.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } slot_t;

  // Handshake between the queue and the execution unit.
  typedef struct packed {
    logic valid;
    logic hold;
  } fb_stat_t;

endpackage

// ===== rtl/swa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module swa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/swa_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module swa_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 8,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned NW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   cand;
  logic [VW:0]   diff;
  logic          ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    cand   = {rem_q, dvd_q[DW-1]};
    diff   = cand - {1'b0, div_q};
    ge     = (cand >= {1'b0, div_q});
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = NW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      rem_d = ge ? diff[VW-1:0] : cand[VW-1:0];
      quo_d = QW'({quo_q, ge});
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/swa_front.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
module swa_front #(
  parameter int unsigned CHANNELS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swa_pkg::in_t      in_data_i,
  input  logic              pop_i,
  output swa_pkg::fb_stat_t stat_o,
  output swa_pkg::qent_t    ent_o,
  input  logic              hold_i
);

  localparam int unsigned QD = 2;

  swa_pkg::qent_t ent_q [QD];
  swa_pkg::qent_t ent_new;
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  logic           bad_ch;

  // Classify the word as it comes in.
  always_comb begin
    bad_ch            = (32'(in_data_i.channel) >= CHANNELS);
    ent_new.channel   = in_data_i.channel;
    ent_new.timestamp = in_data_i.timestamp;
    ent_new.value     = in_data_i.value;
    if (in_data_i.func == swa_pkg::FUNC_GET) begin
      ent_new.cls = bad_ch ? swa_pkg::CLS_BAD_GET : swa_pkg::CLS_GET;
    end else begin
      ent_new.cls = bad_ch ? swa_pkg::CLS_BAD_ADD : swa_pkg::CLS_ADD;
    end
  end

  assign in_ready_o = (cnt_q != 2'(QD)) && !hold_i;
  assign push       = in_valid_i && in_ready_o;

  // Queue pointers and fill level.
  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= ent_new;
    end
  end

  assign ent_o        = ent_q[rptr_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.hold  = hold_i;

endmodule

// ===== rtl/swa_back.sv =====
// Back end: advances channel time, clears buckets, accumulates and divides.
module swa_back #(
  parameter int unsigned CHANNELS   = 5,
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]   w_i,
  input  logic                                cfg_we_i,
  input  swa_pkg::fb_stat_t                   stat_i,
  input  swa_pkg::qent_t                      ent_i,
  output logic                                pop_o,
  output logic                                clr_busy_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output swa_pkg::out_t                       out_data_o
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WI    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned DEPTH = CHANNELS * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DDW   = swa_pkg::SUM_W + swa_pkg::FRAC_W;
  localparam int unsigned SW    = $bits(swa_pkg::slot_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLRALL = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_CLR    = 4'd4;
  localparam logic [3:0] S_POST   = 4'd5;
  localparam logic [3:0] S_ACC    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Bucket address of window index i of channel c.
  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c,
                                               input logic [WI-1:0] i);
    return AW'(32'(c) * MAX_WINDOW + 32'(i));
  endfunction

  logic [3:0]                 state_q, state_d;
  logic                       clr_pend_q, clr_pend_d;
  logic [AW-1:0]              sweep_q, sweep_d;
  swa_pkg::cls_e              cls_q, cls_d;
  logic [CW-1:0]              ch_q, ch_d;
  logic [swa_pkg::TS_W-1:0]   ts_q, ts_d;
  logic [swa_pkg::VAL_W-1:0]  val_q, val_d;
  logic [WI-1:0]              m_q, m_d;
  logic [WI-1:0]              idx_q, idx_d;
  logic [WW-1:0]              left_q, left_d;
  logic                       pend_q, pend_d;
  logic [AW-1:0]              pend_addr_q, pend_addr_d;
  logic                       neg_q, neg_d;
  swa_pkg::out_t              res_q, res_d;
  swa_pkg::out_t              out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic [swa_pkg::SUM_W-1:0]  csum_q [CHANNELS];
  logic [swa_pkg::SUM_W-1:0]  csum_d [CHANNELS];
  logic [swa_pkg::CNT_W-1:0]  ccnt_q [CHANNELS];
  logic [swa_pkg::CNT_W-1:0]  ccnt_d [CHANNELS];
  logic [swa_pkg::TS_W-1:0]   newest_q [CHANNELS];
  logic [swa_pkg::TS_W-1:0]   newest_d [CHANNELS];
  logic                       seen_q [CHANNELS];
  logic                       seen_d [CHANNELS];

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  swa_pkg::slot_t             ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  swa_pkg::slot_t             rd_slot;

  logic                       mod_start;
  logic                       mod_done;
  logic [WW-1:0]              mod_rem;
  logic                       mod_quo;
  logic                       div_start;
  logic                       div_done;
  logic [DDW-1:0]             div_dvd;
  logic [swa_pkg::AVG_W-1:0]  div_quo;
  logic [swa_pkg::CNT_W-1:0]  div_rem;

  logic                       stale;
  logic                       adv;
  logic [31:0]                diff32;
  logic [WW-1:0]              n_clr;
  logic [WW:0]                start_s;
  logic [swa_pkg::SUM_W-1:0]  mag;
  logic [swa_pkg::SUM_W-1:0]  cur_sum;
  logic [swa_pkg::CNT_W-1:0]  cur_cnt;

  swa_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_slot)
  );

  // Bucket index of the item's tick: timestamp mod window.
  swa_div #(
    .DW (swa_pkg::TS_W),
    .VW (WW),
    .QW (1)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (ts_q),
    .divisor_i  (w_i),
    .done_o     (mod_done),
    .quo_o      (mod_quo),
    .rem_o      (mod_rem)
  );

  // Fixed-point average: magnitude scaled by 2^16 over the count.
  swa_div #(
    .DW (DDW),
    .VW (swa_pkg::CNT_W),
    .QW (swa_pkg::AVG_W)
  ) u_avg_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cur_cnt),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Values of the current channel and the derived advance figures.
  always_comb begin
    cur_sum = csum_q[ch_q];
    cur_cnt = ccnt_q[ch_q];
    stale   = seen_q[ch_q] && ((32'(ts_q) + 32'(w_i)) <= 32'(newest_q[ch_q]));
    adv     = !seen_q[ch_q] || (ts_q > newest_q[ch_q]);
    diff32  = seen_q[ch_q] ? 32'(ts_q - newest_q[ch_q]) : (32'(ts_q) + 32'd1);
    n_clr   = (diff32 > 32'(w_i)) ? w_i : WW'(diff32);
    start_s = (WW+1)'(mod_rem) + (WW+1)'(w_i) - (WW+1)'(n_clr) + (WW+1)'(1);
    if (start_s >= (WW+1)'(w_i)) begin
      start_s = start_s - (WW+1)'(w_i);
    end
    mag     = cur_sum[swa_pkg::SUM_W-1] ? (swa_pkg::SUM_W'(0) - cur_sum) : cur_sum;
    div_dvd = {mag, {swa_pkg::FRAC_W{1'b0}}};
  end

  // Sequencer of the back end.
  always_comb begin
    state_d     = state_q;
    clr_pend_d  = clr_pend_q;
    sweep_d     = sweep_q;
    cls_d       = cls_q;
    ch_d        = ch_q;
    ts_d        = ts_q;
    val_d       = val_q;
    m_d         = m_q;
    idx_d       = idx_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    csum_d      = csum_q;
    ccnt_d      = ccnt_q;
    newest_d    = newest_q;
    seen_d      = seen_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = slot_addr(ch_q, m_q);
    mod_start   = 1'b0;
    div_start   = 1'b0;
    pop_o       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (clr_pend_q) begin
          sweep_d = '0;
          state_d = S_CLRALL;
        end else if (stat_i.valid && !stat_i.hold) begin
          pop_o   = 1'b1;
          cls_d   = ent_i.cls;
          ch_d    = CW'(32'(ent_i.channel));
          ts_d    = ent_i.timestamp;
          val_d   = ent_i.value;
          state_d = S_CHK;
        end
      end

      // Sweep all buckets and totals back to zero.
      S_CLRALL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          csum_d[c]   = '0;
          ccnt_d[c]   = '0;
          newest_d[c] = '0;
          seen_d[c]   = 1'b0;
        end
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(DEPTH - 1)) begin
          clr_pend_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      S_CHK: begin
        res_d = '0;
        case (cls_q)
          swa_pkg::CLS_BAD_ADD: begin
            res_d.status = swa_pkg::STAT_STALE;
            state_d      = S_DONE;
          end
          swa_pkg::CLS_BAD_GET: begin
            res_d.status    = swa_pkg::STAT_AVG;
            res_d.empty_res = 1'b1;
            state_d         = S_DONE;
          end
          swa_pkg::CLS_ADD: begin
            if (stale) begin
              res_d.status = swa_pkg::STAT_STALE;
              state_d      = S_DONE;
            end else begin
              mod_start = 1'b1;
              state_d   = S_MOD;
            end
          end
          default: begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        endcase
      end

      // Once the tick index is known, set up the bucket clearing run if channel time advances.
      S_MOD: begin
        if (mod_done) begin
          m_d = WI'(mod_rem);
          if (adv) begin
            left_d  = n_clr;
            idx_d   = WI'(start_s);
            pend_d  = 1'b0;
            state_d = S_CLR;
          end else begin
            state_d = S_POST;
          end
        end
      end

      // Read one bucket per cycle; subtract and zero the one read before.
      S_CLR: begin
        if (pend_q) begin
          ram_we       = 1'b1;
          ram_waddr    = pend_addr_q;
          ram_wdata    = '0;
          csum_d[ch_q] = cur_sum - rd_slot.sum;
          ccnt_d[ch_q] = cur_cnt - rd_slot.cnt;
        end
        if (left_q != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = slot_addr(ch_q, idx_q);
          pend_d      = 1'b1;
          pend_addr_d = slot_addr(ch_q, idx_q);
          idx_d       = ((WW'(idx_q) + WW'(1)) == w_i) ? '0 : (idx_q + WI'(1));
          left_d      = left_q - WW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            newest_d[ch_q] = ts_q;
            seen_d[ch_q]   = 1'b1;
            state_d        = S_POST;
          end
        end
      end

      S_POST: begin
        if (cls_q == swa_pkg::CLS_GET) begin
          if (cur_cnt == '0) begin
            res_d.status    = swa_pkg::STAT_AVG;
            res_d.empty_res = 1'b1;
            state_d         = S_DONE;
          end else begin
            div_start = 1'b1;
            neg_d     = cur_sum[swa_pkg::SUM_W-1];
            state_d   = S_DIV;
          end
        end else if (cur_cnt == '1) begin
          res_d.status = swa_pkg::STAT_OVF;
          state_d      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(ch_q, m_q);
          state_d   = S_ACC;
        end
      end

      // Add the sample into its bucket and into the totals.
      S_ACC: begin
        ram_we        = 1'b1;
        ram_waddr     = slot_addr(ch_q, m_q);
        ram_wdata.sum = rd_slot.sum + {{32{val_q[31]}}, val_q};
        ram_wdata.cnt = rd_slot.cnt + 32'd1;
        csum_d[ch_q]  = cur_sum + {{32{val_q[31]}}, val_q};
        ccnt_d[ch_q]  = cur_cnt + 32'd1;
        res_d.status  = swa_pkg::STAT_ADDED;
        state_d       = S_DONE;
      end

      S_DIV: begin
        if (div_done) begin
          res_d.status  = swa_pkg::STAT_AVG;
          res_d.average = neg_q ? (swa_pkg::AVG_W'(0) - div_quo) : div_quo;
          state_d       = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      clr_pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_pend_q  <= 1'b1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        csum_q[c]   <= '0;
        ccnt_q[c]   <= '0;
        newest_q[c] <= '0;
        seen_q[c]   <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      clr_pend_q  <= clr_pend_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      csum_q      <= csum_d;
      ccnt_q      <= ccnt_d;
      newest_q    <= newest_d;
      seen_q      <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sweep_q     <= sweep_d;
    cls_q       <= cls_d;
    ch_q        <= ch_d;
    ts_q        <= ts_d;
    val_q       <= val_d;
    m_q         <= m_d;
    idx_q       <= idx_d;
    left_q      <= left_d;
    pend_addr_q <= pend_addr_d;
    neg_q       <= neg_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign clr_busy_o  = clr_pend_q || (state_q == S_CLRALL);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/per_channel_sliding_time_window_average.sv =====
// Top level of the per-channel sliding time-window average block.
// A word that is not rejected outright first runs the 31-step index divider to find its
// bucket. When the channel time advances, the buckets that it passes, at most one window
// of them, are cleared one per cycle through the slot memory port; a query on a channel
// with a nonzero count then runs the 80-step average divider. One word is worked on at a
// time, and a two-word queue takes new words meanwhile. After reset and after each
// window_len write, a clearing pass over all CHANNELS*MAX_WINDOW buckets runs before words are accepted.
module per_channel_sliding_time_window_average #(
  parameter int unsigned CHANNELS   = 5,
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  swa_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output swa_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [swa_pkg::WLEN_W-1:0]    cfg_wdata_i
);

  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);

  logic [swa_pkg::WLEN_W-1:0] wlen_q, wlen_d;
  logic [WW-1:0]              w_eff;
  logic                       pop;
  logic                       clr_busy;
  swa_pkg::fb_stat_t          fb_stat;
  swa_pkg::qent_t             ent;

  // Window length register.
  assign wlen_d = cfg_we_i ? cfg_wdata_i : wlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= swa_pkg::WLEN_RESET;
    end else begin
      wlen_q <= wlen_d;
    end
  end

  // Effective window, saturated into 1..MAX_WINDOW.
  always_comb begin
    if (wlen_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(wlen_q);
    end
  end

  swa_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .stat_o     (fb_stat),
    .ent_o      (ent),
    .hold_i     (clr_busy)
  );

  swa_back #(
    .CHANNELS   (CHANNELS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_i         (w_eff),
    .cfg_we_i    (cfg_we_i),
    .stat_i      (fb_stat),
    .ent_i       (ent),
    .pop_o       (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
